FILE: hw/rtl/gf2m_poly_basis_alu_macros.svh
// ----------------------------------------------------------------------------
// gf2m_poly_basis_alu_macros.svh
// Assertion macros shared by the GF(2^M) unit.
// ----------------------------------------------------------------------------
`ifndef GF2M_POLY_BASIS_ALU_MACROS_SVH
`define GF2M_POLY_BASIS_ALU_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define GPA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define GPA_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define GPA_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: hw/rtl/gpa_pkg.sv
// ----------------------------------------------------------------------------
// gpa_pkg
// Op codes and shared types of the GF(2^M) arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpa_pkg;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_MUL   = 3'd1,
		OP_SQR   = 3'd2,
		OP_INV   = 3'd3,
		OP_DIV   = 3'd4,
		OP_POW   = 3'd5,
		OP_TRACE = 3'd6,
		OP_NONE  = 3'd7
	} gpa_op_t;

	// status of the serial multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gpa_cell.sv
// ----------------------------------------------------------------------------
// gpa_cell
// One bit of the shift-and-add product register with on-the-fly reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_cell (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic clr,
	input  wire logic r_in,    // neighbor bit below
	input  wire logic top,     // product MSB, drives reduction
	input  wire logic p,       // polynomial bit
	input  wire logic x,       // multiplicand bit
	input  wire logic y_bit,   // current multiplier bit
	output logic      r
);

	logic r_q;

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= clr ? 1'b0 : (r_in ^ (top & p) ^ (y_bit & x));
		end
	end

	assign r = r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gpa_mul.sv
// ----------------------------------------------------------------------------
// gpa_mul
// Bit-serial GF(2^M) multiplier: a row of M cells, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2m_poly_basis_alu_macros.svh"

module gpa_mul #(
	parameter int M = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [M-1:0]        x,
	input  wire logic [M-1:0]        y,
	input  wire logic [M-1:0]        poly,
	output logic      [M-1:0]        prod,
	output gpa_pkg::mul_stat_t       stat
);
	import gpa_pkg::*;

	localparam int CW = $clog2(M);

	logic [M-1:0]  x_q;
	logic [M-1:0]  y_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [M-1:0]  r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(M - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operands, MSB of y first
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			y_q <= y_q << 1;
		end
	end

	for (genvar i = 0; i < M; i++) begin : g_cell
		gpa_cell u_cell (
			.clk   (clk),
			.en    (start | busy_q),
			.clr   (start),
			.r_in  ((i == 0) ? 1'b0 : r[(i == 0) ? 0 : i-1]),
			.top   (r[M-1]),
			.p     (poly[i]),
			.x     (x_q[i]),
			.y_bit (y_q[M-1]),
			.r     (r[i])
		);
	end

	assign prod      = r;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`GPA_NEVER(a_start_busy, clk, arst_n, start && busy_q, "multiply started while busy")
	`GPA_ASSERT(a_last_done, clk, arst_n, (busy_q && cnt_q == '0 && !start) |=> done_q, "no done after last step")
	`GPA_NEVER(a_done_busy, clk, arst_n, done_q && busy_q, "done while still busy")

endmodule

`default_nettype wire

FILE: hw/rtl/gf2m_poly_basis_alu.sv
// ----------------------------------------------------------------------------
// gf2m_poly_basis_alu
// GF(2^M) polynomial-basis unit: add, multiply, square, inverse, divide,
// power and trace around one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
//   channel  | signals                              | direction
//   req      | req_valid, req_stall, op, operand_a/b | in
//   rsp      | rsp_valid, rsp_stall, result, error   | out
//   cfg      | cfg_wr_en, cfg_wr_data                | in
//
// A multiply runs as operand load, M cell steps, then done.
// Add uses no multiply. Multiply/square: one. Power: up to 2M multiplies.
// Inverse raises to 2^M-2, divide one multiply more, trace (M-1) multiplies.
// All of these run on the one shared multiplier row.
// A new request is taken only when the sequencer is idle; a finished result
// waits in the output register while rsp_stall is high. Reset sets the
// polynomial to x^M + 27.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2m_poly_basis_alu_macros.svh"

module gf2m_poly_basis_alu #(
	parameter int FIELD_DEGREE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [63:0]          cfg_wr_data,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire gpa_pkg::gpa_op_t     op,
	input  wire logic [63:0]          operand_a,
	input  wire logic [63:0]          operand_b,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic [63:0]               result,
	output logic                      error
);
	import gpa_pkg::*;

	localparam int M  = FIELD_DEGREE;
	localparam int CW = $clog2(M);

	typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_POW, ST_FIN} state_t;
	typedef enum logic [1:0] {PH_R, PH_T, PH_FINAL, PH_TRACE} phase_t;

	state_t        state_q;
	phase_t        phase_q;
	gpa_op_t       op_q;
	logic [63:0]   poly_q;
	logic [M-1:0]  a_q, r_q, t_q, e_q, res_q;
	logic [M-1:0]  mx_q, my_q;
	logic [CW-1:0] cnt_q;
	logic          err_q, res_err_q, mstart_q, rsp_valid_q;
	logic [M-1:0]  in_a, in_b, prod;
	logic          accept;
	mul_stat_t     mstat;

	assign in_a   = operand_a[M-1:0];
	assign in_b   = operand_b[M-1:0];
	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= 64'd27;
		end else if (cfg_wr_en) begin
			poly_q <= cfg_wr_data;
		end
	end

	gpa_mul #(.M(M)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.x      (mx_q),
		.y      (my_q),
		.poly   (poly_q[M-1:0]),
		.prod   (prod),
		.stat   (mstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FINAL;
			op_q        <= OP_ADD;
			mstart_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			err_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			mstart_q <= 1'b0;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= op;
						a_q   <= in_a;
						err_q <= 1'b0;
						res_q <= '0;
						r_q   <= M'(1);
						state_q <= ST_FIN;
						case (op)
							OP_ADD: res_q <= in_a ^ in_b;
							OP_MUL, OP_SQR: begin
								mx_q     <= in_a;
								my_q     <= (op == OP_MUL) ? in_b : in_a;
								mstart_q <= 1'b1;
								phase_q  <= PH_FINAL;
								state_q  <= ST_WAIT;
							end
							OP_INV: begin
								if (in_a == '0) begin
									err_q <= 1'b1;
								end else begin
									t_q     <= in_a;
									e_q     <= {{(M-1){1'b1}}, 1'b0};
									state_q <= ST_POW;
								end
							end
							OP_DIV: begin
								if (in_b == '0) begin
									err_q <= 1'b1;
								end else begin
									t_q     <= in_b;
									e_q     <= {{(M-1){1'b1}}, 1'b0};
									state_q <= ST_POW;
								end
							end
							OP_POW: begin
								if (in_a != '0) begin
									t_q     <= in_a;
									e_q     <= in_b;
									state_q <= ST_POW;
								end
							end
							OP_TRACE: begin
								r_q      <= in_a;     // running sum
								cnt_q    <= CW'(M - 1);
								mx_q     <= in_a;
								my_q     <= in_a;
								mstart_q <= 1'b1;
								phase_q  <= PH_TRACE;
								state_q  <= ST_WAIT;
							end
							default: ;
						endcase
					end
				end
				ST_POW: begin
					state_q  <= ST_WAIT;
					mstart_q <= 1'b1;
					if (e_q == '0) begin
						if (op_q == OP_DIV) begin
							mx_q    <= a_q;
							my_q    <= r_q;
							phase_q <= PH_FINAL;
						end else begin
							mstart_q <= 1'b0;
							res_q    <= r_q;
							state_q  <= ST_FIN;
						end
					end else if (e_q[0]) begin
						mx_q    <= r_q;
						my_q    <= t_q;
						phase_q <= PH_R;
					end else begin
						mx_q    <= t_q;
						my_q    <= t_q;
						phase_q <= PH_T;
					end
				end
				ST_WAIT: begin
					if (mstat.done) begin
						case (phase_q)
							PH_R: begin
								r_q      <= prod;
								mx_q     <= t_q;
								my_q     <= t_q;
								mstart_q <= 1'b1;
								phase_q  <= PH_T;
							end
							PH_T: begin
								t_q     <= prod;
								e_q     <= e_q >> 1;
								state_q <= ST_POW;
							end
							PH_TRACE: begin
								r_q <= r_q ^ prod;
								if (cnt_q == CW'(1)) begin
									res_q   <= r_q ^ prod;
									state_q <= ST_FIN;
								end else begin
									cnt_q    <= cnt_q - 1'b1;
									mx_q     <= prod;
									my_q     <= prod;
									mstart_q <= 1'b1;
								end
							end
							default: begin
								res_q   <= prod;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						res_err_q   <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register is loaded in the same transaction as rsp_valid
	logic [M-1:0] out_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			out_q <= res_q;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign result    = 64'(out_q);
	assign error     = res_err_q;

	`GPA_ASSERT(a_start_busy, clk, arst_n, mstart_q |=> mstat.busy, "multiplier did not start")
	`GPA_ASSERT(a_rise_fin, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == ST_FIN), "result without finish")
	`GPA_ASSERT(a_err_op, clk, arst_n, (state_q == ST_FIN && err_q) |-> (op_q == OP_INV || op_q == OP_DIV), "error on wrong op")

endmodule

`default_nettype wire
